// File: hdl/cile_pkg.sv
// Shared types and byte constants for the character literal encoder.
`default_nettype none

package cile_pkg;

  localparam int unsigned MAX_RUN = 7;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] run_len_t;

  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    run_len_t                len;
  } lit_desc_t;

  localparam byte_t CH_QMARK  = 8'h3F;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_CARET  = 8'h5E;
  localparam byte_t CH_T      = 8'h74;
  localparam byte_t CH_N      = 8'h6E;
  localparam byte_t CH_R      = 8'h72;

  localparam logic [30:0] CODE_TAB = 31'h09;
  localparam logic [30:0] CODE_LF  = 31'h0A;
  localparam logic [30:0] CODE_CR  = 31'h0D;
  localparam logic [30:0] CODE_FS  = 31'h1C;
  localparam logic [30:0] CODE_DEL = 31'h7F;

endpackage

`default_nettype wire

// File: hdl/cile_front.sv
// Front end: accepts a character code and builds the full byte run of its literal.
`default_nettype none

module cile_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [30:0]       char_code,
  output logic                   f_valid,
  input  wire logic              f_ready,
  output cile_pkg::lit_desc_t    f_desc
);
  import cile_pkg::*;

  lit_desc_t d;
  logic      needs_bs;
  logic      low7;

  assign low7 = (char_code[30:7] == 24'd0);

  always_comb begin
    case (char_code[6:0])
      7'h20, 7'h22, 7'h23, 7'h27, 7'h28, 7'h29, 7'h2C,
      7'h2E, 7'h3B, 7'h3F, 7'h5B, 7'h5C, 7'h5D, 7'h60: needs_bs = low7;
      default: needs_bs = 1'b0;
    endcase
  end

  always_comb begin
    d          = '0;
    d.bytes[0] = CH_QMARK;
    if (char_code == CODE_TAB || char_code == CODE_LF || char_code == CODE_CR) begin
      d.bytes[1] = CH_BSLASH;
      d.bytes[2] = char_code[2] ? CH_R : (char_code[0] ? CH_T : CH_N);
      d.len      = 3'd3;
    end else if (char_code == CODE_FS) begin
      d.bytes[1] = CH_BSLASH;
      d.bytes[2] = CH_CARET;
      d.bytes[3] = CH_BSLASH;
      d.bytes[4] = CH_BSLASH;
      d.len      = 3'd5;
    end else if (char_code[30:5] == 26'd0) begin
      d.bytes[1] = CH_BSLASH;
      d.bytes[2] = CH_CARET;
      d.bytes[3] = {3'b010, char_code[4:0]};
      d.len      = 3'd4;
    end else if (needs_bs) begin
      d.bytes[1] = CH_BSLASH;
      d.bytes[2] = char_code[7:0];
      d.len      = 3'd3;
    end else if (low7 && char_code != CODE_DEL) begin
      d.bytes[1] = char_code[7:0];
      d.len      = 3'd2;
    end else if (char_code == CODE_DEL) begin
      d.bytes[1] = CH_BSLASH;
      d.bytes[2] = CH_CARET;
      d.bytes[3] = CH_QMARK;
      d.len      = 3'd4;
    end else if (char_code[30:8] == 23'd0 && char_code[7:5] == 3'b100) begin
      // The code plus 0x40 always lands in 0xC0..0xDF, so its lead byte is fixed.
      d.bytes[1] = CH_BSLASH;
      d.bytes[2] = CH_CARET;
      d.bytes[3] = 8'hC3;
      d.bytes[4] = {2'b10, char_code[5:0]};
      d.len      = 3'd5;
    end else if (char_code[30:11] == 20'd0) begin
      d.bytes[1] = {3'b110, char_code[10:6]};
      d.bytes[2] = {2'b10, char_code[5:0]};
      d.len      = 3'd3;
    end else if (char_code[30:16] == 15'd0) begin
      d.bytes[1] = {4'b1110, char_code[15:12]};
      d.bytes[2] = {2'b10, char_code[11:6]};
      d.bytes[3] = {2'b10, char_code[5:0]};
      d.len      = 3'd4;
    end else if (char_code[30:21] == 10'd0) begin
      d.bytes[1] = {5'b11110, char_code[20:18]};
      d.bytes[2] = {2'b10, char_code[17:12]};
      d.bytes[3] = {2'b10, char_code[11:6]};
      d.bytes[4] = {2'b10, char_code[5:0]};
      d.len      = 3'd5;
    end else if (char_code[30:26] == 5'd0) begin
      d.bytes[1] = {6'b111110, char_code[25:24]};
      d.bytes[2] = {2'b10, char_code[23:18]};
      d.bytes[3] = {2'b10, char_code[17:12]};
      d.bytes[4] = {2'b10, char_code[11:6]};
      d.bytes[5] = {2'b10, char_code[5:0]};
      d.len      = 3'd6;
    end else begin
      d.bytes[1] = {7'b1111110, char_code[30]};
      d.bytes[2] = {2'b10, char_code[29:24]};
      d.bytes[3] = {2'b10, char_code[23:18]};
      d.bytes[4] = {2'b10, char_code[17:12]};
      d.bytes[5] = {2'b10, char_code[11:6]};
      d.bytes[6] = {2'b10, char_code[5:0]};
      d.len      = 3'd7;
    end
  end

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_desc <= d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cile_queue.sv
// Small register queue of literal descriptors between the front and back ends.
`default_nettype none

module cile_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire cile_pkg::lit_desc_t push_desc,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output cile_pkg::lit_desc_t    pop_desc
);
  import cile_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  lit_desc_t         slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_desc   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cile_back.sv
// Back end: serializes a literal descriptor into output words, one byte per cycle unless stalled.
`default_nettype none

module cile_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire cile_pkg::lit_desc_t q_desc,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic [2:0]             run_length,
  output logic                   is_last
);
  import cile_pkg::*;

  lit_desc_t cur;
  logic      cur_valid;
  logic [2:0] idx;
  logic      emit;
  logic      at_end;
  logic      take;

  assign emit    = cur_valid && (!out_valid || out_ready);
  assign at_end  = (idx == cur.len - 3'd1);
  assign take    = q_valid && (!cur_valid || (emit && at_end));
  assign q_ready = !cur_valid || (emit && at_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (emit && at_end) begin
      cur_valid <= 1'b0;
    end else if (emit) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= cur.bytes[idx];
      run_length <= cur.len;
      is_last    <= at_end;
    end
  end

endmodule

`default_nettype wire

// File: hdl/char_id_literal_encoder_core.sv
// Top level of the character literal encoder: front end, descriptor queue and byte serializer.
// Each accepted character code produces run_length output words (2 to 7), one byte per
// cycle while the output is not stalled, the question mark first and is_last on the final
// byte. The byte serializer in the back end sets the rate, and the next code's first byte
// can follow its predecessor's last byte with no gap when the queue holds it. The front end
// keeps taking codes while the output side stalls, until the front-end register and the
// descriptor queue are full. On its way out a code passes the front-end register, a queue
// slot, the serializer's current descriptor and the output register.
`default_nettype none

module char_id_literal_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [30:0] char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [2:0]       run_length,
  output logic             is_last
);
  import cile_pkg::*;

  logic      f_valid;
  logic      f_ready;
  lit_desc_t f_desc;
  logic      q_valid;
  logic      q_ready;
  lit_desc_t q_desc;

  cile_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_desc    (f_desc)
  );

  cile_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_desc  (f_desc),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_desc   (q_desc)
  );

  cile_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_desc     (q_desc),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_length (run_length),
    .is_last    (is_last)
  );

endmodule

`default_nettype wire

// File: hdl/cile_checker.sv
// Port-level checks for the character literal encoder and their bind to the top level.
`default_nettype none

module cile_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] run_length,
  input wire logic       is_last
);
  import cile_pkg::*;

  logic at_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (out_valid && out_ready) begin
      at_start <= is_last;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Output word dropped while stalled.");

  a_run_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_length >= 3'd2))
    else $error("Run length below two.");

  a_lead_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_start |-> (out_byte == CH_QMARK) && !is_last)
    else $error("Literal does not open with a question mark.");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !is_last |=> out_valid && $stable(run_length))
    else $error("Literal run broken or run length changed.");

endmodule

bind char_id_literal_encoder_core cile_checker u_cile_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .run_length (run_length),
  .is_last    (is_last)
);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the character literal encoder: directed table, then random codes.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cile_pkg::*;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 125;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    byte_t    value;
    run_len_t len;
    logic     last;
  } lit_byte_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [30:0] char_code;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [2:0]  run_length;
  logic        is_last;

  lit_byte_t expected_bytes[$];
  int        codes_sent;
  int        words_seen;
  int        mismatches;
  int        cycles;

  // A length of zero means the row is checked against the predictor.
  logic [30:0] dir_code  [NUM_DIRECTED] = '{
    31'h00, 31'h09, 31'h0A, 31'h0D, 31'h1C, 31'h1F, 31'h20, 31'h22, 31'h41,
    31'h5C, 31'h60, 31'h7E, 31'h7F, 31'h80, 31'h9F, 31'hA0, 31'h7FF, 31'h800,
    31'hFFFF, 31'h10000, 31'h1FFFFF, 31'h200000, 31'h3FFFFFF, 31'h4000000,
    31'h7FFFFFFF
  };
  int          dir_len   [NUM_DIRECTED] = '{
    4, 3, 0, 0, 5, 0, 0, 0, 2, 0, 0, 0, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7
  };
  logic [55:0] dir_bytes [NUM_DIRECTED] = '{
    56'h3F5C5E40000000, 56'h3F5C7400000000, 56'h0, 56'h0, 56'h3F5C5E5C5C0000,
    56'h0, 56'h0, 56'h0, 56'h3F410000000000, 56'h0, 56'h0, 56'h0,
    56'h3F5C5E3F000000, 56'h0, 56'h0, 56'h0, 56'h0, 56'h0, 56'h0, 56'h0,
    56'h0, 56'h0, 56'h0, 56'h0, 56'h3FFDBFBFBFBFBF
  };

  char_id_literal_encoder_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_length (run_length),
    .is_last    (is_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void predict_literal(input logic [30:0] c);
    byte_t       body [7];
    int          n;
    int          nb;
    int          k;
    logic [31:0] v;
    logic [31:0] part;
    byte_t       mark;
    logic        punct;
    lit_byte_t   e;
    n = 1;
    nb = 0;
    v = {1'b0, c};
    body[0] = CH_QMARK;
    case (c)
      31'h20, 31'h22, 31'h23, 31'h27, 31'h28, 31'h29, 31'h2C, 31'h2E,
      31'h3B, 31'h3F, 31'h5B, 31'h5C, 31'h5D, 31'h60: punct = 1'b1;
      default: punct = 1'b0;
    endcase
    if (c == CODE_TAB || c == CODE_LF || c == CODE_CR) begin
      body[1] = CH_BSLASH;
      body[2] = (c == CODE_TAB) ? CH_T : (c == CODE_LF) ? CH_N : CH_R;
      n = 3;
    end else if (c == CODE_FS) begin
      body[1] = CH_BSLASH;
      body[2] = CH_CARET;
      body[3] = CH_BSLASH;
      body[4] = CH_BSLASH;
      n = 5;
    end else if (c <= 31'h1F) begin
      body[1] = CH_BSLASH;
      body[2] = CH_CARET;
      body[3] = 8'h40 + c[7:0];
      n = 4;
    end else if (punct) begin
      body[1] = CH_BSLASH;
      body[2] = c[7:0];
      n = 3;
    end else if (c <= 31'h7E) begin
      body[1] = c[7:0];
      n = 2;
    end else if (c == CODE_DEL) begin
      body[1] = CH_BSLASH;
      body[2] = CH_CARET;
      body[3] = CH_QMARK;
      n = 4;
    end else if (c <= 31'h9F) begin
      body[1] = CH_BSLASH;
      body[2] = CH_CARET;
      n = 3;
      v = v + 32'h40;
      nb = 2;
    end else if (c <= 31'h7FF) begin
      nb = 2;
    end else if (c <= 31'hFFFF) begin
      nb = 3;
    end else if (c <= 31'h1FFFFF) begin
      nb = 4;
    end else if (c <= 31'h3FFFFFF) begin
      nb = 5;
    end else begin
      nb = 6;
    end
    if (nb != 0) begin
      case (nb)
        2: mark = 8'hC0;
        3: mark = 8'hE0;
        4: mark = 8'hF0;
        5: mark = 8'hF8;
        default: mark = 8'hFC;
      endcase
      part = v >> (6 * (nb - 1));
      body[n] = part[7:0] | mark;
      n++;
      for (k = nb - 2; k >= 0; k--) begin
        part = v >> (6 * k);
        body[n] = {2'b10, part[5:0]};
        n++;
      end
    end
    for (k = 0; k < n; k++) begin
      e.value = body[k];
      e.len = run_len_t'(n);
      e.last = (k == n - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  task automatic send_code(input logic [30:0] code, input int typed_len,
                           input logic [55:0] typed_bytes);
    int        gap;
    int        k;
    lit_byte_t e;
    gap = ((codes_sent / 20) % 3 == 2) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    char_code = code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed_len == 0) begin
      predict_literal(code);
    end else begin
      for (k = 0; k < typed_len; k++) begin
        e.value = typed_bytes[55 - 8 * k -: 8];
        e.len = run_len_t'(typed_len);
        e.last = (k == typed_len - 1);
        expected_bytes.push_back(e);
      end
    end
    codes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [30:0] random_code();
    logic [30:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 31'($urandom_range(0, 8'h7F));
      3: c = 31'($urandom_range(8'h80, 8'hFF));
      4: c = 31'($urandom_range(32'h100, 32'h7FF));
      5: c = 31'($urandom_range(32'h800, 32'hFFFF));
      6: c = 31'($urandom_range(32'h10000, 32'h1FFFFF));
      7: c = 31'($urandom_range(32'h200000, 32'h3FFFFFF));
      8: c = 31'($urandom_range(32'h4000000, 32'h7FFFFFFF));
      default: c = 31'($urandom());
    endcase
    return c;
  endfunction

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = '0;
    out_ready = 1'b0;
    codes_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_code(dir_code[i], dir_len[i], dir_bytes[i]);
    end
    for (i = 0; i < NUM_RANDOM; i++) begin
      send_code(random_code(), 0, 56'h0);
    end
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("testbench: %0d character codes encoded, %0d literal words checked",
             codes_sent, words_seen);
    $display("testbench: control, escape, punctuation and 2- to 6-byte ranges, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = ((words_seen / 30) % 3 == 1) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    lit_byte_t e;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected word: out_byte=%h run_length=%0d is_last=%b",
               out_byte, run_length, is_last);
        mismatches++;
      end else begin
        e = expected_bytes.pop_front();
        if (out_byte !== e.value) begin
          $error("out_byte: expected %h, actual %h", e.value, out_byte);
          mismatches++;
        end
        if (run_length !== e.len) begin
          $error("run_length: expected %0d, actual %0d", e.len, run_length);
          mismatches++;
        end
        if (is_last !== e.last) begin
          $error("is_last: expected %b, actual %b", e.last, is_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    words_seen = 0;
    mismatches = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: timeout after %0d cycles, %0d words still expected",
               cycles, expected_bytes.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

`default_nettype wire

// File: sim.f
hdl/cile_pkg.sv
hdl/cile_front.sv
hdl/cile_queue.sv
hdl/cile_back.sv
hdl/char_id_literal_encoder_core.sv
hdl/cile_checker.sv
verif/testbench.sv
